// File: hw/rtl/assert_macros.svh
// Assertion macros used by the frame state machine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the given reset is low.
`define SRX_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same, on the house clock and reset names of the enclosing module.
`define SRX_ASSERT_CLK(lbl, prop, msg) \
    `SRX_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: hw/rtl/srx_pkg.sv
// Package of types, codes and the CRC-32 table for the SLIP frame receiver.
`default_nettype none

package srx_pkg;

    // SLIP special bytes.
    localparam logic [7:0] FRAME_END = 8'hC0;
    localparam logic [7:0] FRAME_ESC = 8'hDB;
    localparam logic [7:0] TRANS_END = 8'hDC;
    localparam logic [7:0] TRANS_ESC = 8'hDD;

    // Reflected CRC-32 constants.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Receive phase.
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC    = 3'd4
    } t_phase;

    // Status code reported with every result word.
    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_GOOD   = 2'd1,
        ST_BADCRC = 2'd2,
        ST_BADESC = 2'd3
    } t_status;

    // One result word.
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        t_status    status;
    } t_result;

    typedef logic [31:0] t_crc_table [256];

    // Builds the byte-wise CRC table at elaboration.
    function automatic t_crc_table build_crc_table();
        t_crc_table  tab;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam t_crc_table CRC_TABLE = build_crc_table();

    // Advances the CRC register by one byte through the table.
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        return {8'h00, crc[31:8]} ^ CRC_TABLE[crc[7:0] ^ b];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srx_frame_fsm.sv
// Frame state machine: escape removal, length, payload count and CRC check.
`default_nettype none

`include "assert_macros.svh"

module srx_frame_fsm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_byte,
    output srx_pkg::t_result     o_result
);

    srx_pkg::t_phase r_phase, n_phase;
    logic            r_escape, n_escape;
    logic [15:0]     r_frame_length, n_frame_length;
    logic [15:0]     r_payload_count, n_payload_count;
    logic [31:0]     r_running_crc, n_running_crc;
    logic [1:0]      r_crc_byte_count, n_crc_byte_count;
    logic [31:0]     r_received_crc, n_received_crc;

    logic            in_frame;
    logic            esc_start;
    logic            bad_esc;
    logic            have_sym;
    logic [7:0]      sym;
    logic [31:0]     crc_next;
    logic [15:0]     count_inc;
    logic [15:0]     length_full;
    logic [31:0]     received_full;
    logic            crc_match;

    // Escape removal and the shared datapath terms.
    always_comb begin
        in_frame  = (r_phase == srx_pkg::PH_LEN_LO) || (r_phase == srx_pkg::PH_LEN_HI) ||
                    (r_phase == srx_pkg::PH_DATA)   || (r_phase == srx_pkg::PH_CRC);
        esc_start = 1'b0;
        bad_esc   = 1'b0;
        have_sym  = 1'b0;
        sym       = i_byte;
        if (in_frame) begin
            if (!r_escape) begin
                if (i_byte == srx_pkg::FRAME_ESC) begin
                    esc_start = 1'b1;
                end else begin
                    have_sym = 1'b1;
                end
            end else if (i_byte == srx_pkg::TRANS_END) begin
                sym      = srx_pkg::FRAME_END;
                have_sym = 1'b1;
            end else if (i_byte == srx_pkg::TRANS_ESC) begin
                sym      = srx_pkg::FRAME_ESC;
                have_sym = 1'b1;
            end else begin
                bad_esc = 1'b1;
            end
        end
        crc_next      = srx_pkg::crc_update(r_running_crc, sym);
        count_inc     = r_payload_count + 16'd1;
        length_full   = {sym, r_frame_length[7:0]};
        received_full = {sym, r_received_crc[23:0]};
        crc_match     = (received_full == (r_running_crc ^ srx_pkg::CRC_INIT));
    end

    // Next state.
    always_comb begin
        n_phase          = r_phase;
        n_escape         = r_escape;
        n_frame_length   = r_frame_length;
        n_payload_count  = r_payload_count;
        n_running_crc    = r_running_crc;
        n_crc_byte_count = r_crc_byte_count;
        n_received_crc   = r_received_crc;
        if (!in_frame) begin
            n_phase = srx_pkg::PH_HUNT;
            if (i_byte == srx_pkg::FRAME_END) begin
                n_phase       = srx_pkg::PH_LEN_LO;
                n_running_crc = srx_pkg::CRC_INIT;
                n_escape      = 1'b0;
            end
        end else if (esc_start) begin
            n_escape = 1'b1;
        end else if (bad_esc) begin
            n_escape = 1'b0;
            n_phase  = srx_pkg::PH_HUNT;
        end else begin
            n_escape = 1'b0;
            unique case (r_phase)
                srx_pkg::PH_LEN_LO: begin
                    n_frame_length = {8'h00, sym};
                    n_running_crc  = crc_next;
                    n_phase        = srx_pkg::PH_LEN_HI;
                end
                srx_pkg::PH_LEN_HI: begin
                    n_frame_length  = length_full;
                    n_running_crc   = crc_next;
                    n_payload_count = 16'd0;
                    if (length_full == 16'd0) begin
                        n_phase          = srx_pkg::PH_CRC;
                        n_crc_byte_count = 2'd0;
                    end else begin
                        n_phase = srx_pkg::PH_DATA;
                    end
                end
                srx_pkg::PH_DATA: begin
                    n_running_crc   = crc_next;
                    n_payload_count = count_inc;
                    if (count_inc >= r_frame_length) begin
                        n_phase          = srx_pkg::PH_CRC;
                        n_crc_byte_count = 2'd0;
                    end
                end
                srx_pkg::PH_CRC: begin
                    unique case (r_crc_byte_count)
                        2'd0: n_received_crc[7:0]   = sym;
                        2'd1: n_received_crc[15:8]  = sym;
                        2'd2: n_received_crc[23:16] = sym;
                        2'd3: n_received_crc[31:24] = sym;
                    endcase
                    if (r_crc_byte_count == 2'd3) begin
                        n_crc_byte_count = 2'd0;
                        n_phase          = srx_pkg::PH_HUNT;
                    end else begin
                        n_crc_byte_count = r_crc_byte_count + 2'd1;
                    end
                end
                default: begin
                    n_phase = srx_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Result word for the byte now being consumed.
    always_comb begin
        o_result.data_valid = 1'b0;
        o_result.data_byte  = 8'h00;
        o_result.status     = srx_pkg::ST_BUSY;
        if (bad_esc) begin
            o_result.status = srx_pkg::ST_BADESC;
        end else if (have_sym && (r_phase == srx_pkg::PH_DATA)) begin
            o_result.data_valid = 1'b1;
            o_result.data_byte  = sym;
        end else if (have_sym && (r_phase == srx_pkg::PH_CRC) &&
                     (r_crc_byte_count == 2'd3)) begin
            o_result.status = crc_match ? srx_pkg::ST_GOOD : srx_pkg::ST_BADCRC;
        end
    end

    // State registers advance once per consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= srx_pkg::PH_HUNT;
            r_escape         <= 1'b0;
            r_frame_length   <= 16'd0;
            r_payload_count  <= 16'd0;
            r_running_crc    <= srx_pkg::CRC_INIT;
            r_crc_byte_count <= 2'd0;
            r_received_crc   <= 32'd0;
        end else if (i_en) begin
            r_phase          <= n_phase;
            r_escape         <= n_escape;
            r_frame_length   <= n_frame_length;
            r_payload_count  <= n_payload_count;
            r_running_crc    <= n_running_crc;
            r_crc_byte_count <= n_crc_byte_count;
            r_received_crc   <= n_received_crc;
        end
    end

    // Payload bytes come only from the payload phase.
    `SRX_ASSERT_CLK(a_data_in_payload, (i_en && o_result.data_valid) |-> (r_phase == srx_pkg::PH_DATA), "payload byte emitted outside the payload phase")
    // A CRC verdict only follows the last CRC byte, and the frame then closes.
    `SRX_ASSERT_CLK(a_verdict_at_end, (i_en && ((o_result.status == srx_pkg::ST_GOOD) || (o_result.status == srx_pkg::ST_BADCRC))) |=> (r_phase == srx_pkg::PH_HUNT), "CRC verdict without returning to hunt")
    // The payload counter stays below the length while in the payload phase.
    `SRX_ASSERT(a_count_below_length, i_clk, i_rst_n, (r_phase == srx_pkg::PH_DATA) |-> (r_payload_count < r_frame_length), "payload count reached the length inside the payload phase")

endmodule

`default_nettype wire

// File: hw/rtl/srx_out_reg.sv
// Output register holding one result word until the receiver takes it.
`default_nettype none

module srx_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire srx_pkg::t_result i_result,
    input  wire logic             i_stall,
    output logic                  o_free,
    output logic                  o_valid,
    output srx_pkg::t_result      o_result
);

    logic             r_valid;
    srx_pkg::t_result r_result;

    // The register can take a word when empty or when its word leaves now.
    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/slip_crc32_frame_receiver.sv
// A link byte accepted into the input register is decoded, its result word loaded into
// the output register. Throughput: one byte per cycle unless stalled; one result word
// per byte, in order. The rate is set by the frame state machine, which consumes one
// byte per cycle with a table-driven CRC update. Synchronous active-low reset empties
// both registers and returns to hunting for a frame start; no clearing pass is needed.
`default_nettype none

module slip_crc32_frame_receiver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_link_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_data_valid,
    output logic [7:0]      o_data_byte,
    output logic [1:0]      o_status
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             accept;
    logic             advance;
    logic             out_free;
    srx_pkg::t_result fsm_result;
    srx_pkg::t_result out_result;

    // Input register: holds a word until the frame logic consumes it.
    assign advance = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_link_byte;
        end
    end

    // Frame decoding between the two registers.
    srx_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_byte   (r_in_byte),
        .o_result (fsm_result)
    );

    // Result register towards the downstream side.
    srx_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (fsm_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_data_valid = out_result.data_valid;
    assign o_data_byte  = out_result.data_byte;
    assign o_status     = out_result.status;

endmodule

`default_nettype wire

// File: tb/slip_crc32_frame_receiver_tb.sv
// Self-checking testbench for the SLIP frame receiver with length field and CRC-32 check.
module slip_crc32_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the frame decoder and holds the result words still due from the block.
    class slip_rx_tracker;
        srx_pkg::t_phase  phase;
        bit               esc_seen;
        logic [15:0]      frame_len;
        logic [15:0]      pay_count;
        logic [31:0]      crc_acc;
        logic [31:0]      crc_rx;
        logic [1:0]       crc_idx;
        srx_pkg::t_result pending_words[$];
        int unsigned      mismatches;

        function new();
            phase      = srx_pkg::PH_HUNT;
            esc_seen   = 1'b0;
            frame_len  = '0;
            pay_count  = '0;
            crc_acc    = srx_pkg::CRC_INIT;
            crc_rx     = '0;
            crc_idx    = '0;
            mismatches = 0;
        endfunction

        // Reflected CRC-32, one bit at a time.
        static function logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'h0, b};
            for (int i = 0; i < 8; i++) begin
                r = r[0] ? ((r >> 1) ^ srx_pkg::CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        // Works out the result word for one accepted link byte.
        function void note_link_byte(input logic [7:0] b);
            srx_pkg::t_result w;
            logic [7:0]       sym;
            bit               have_sym;
            w.data_valid = 1'b0;
            w.data_byte  = 8'h00;
            w.status     = srx_pkg::ST_BUSY;
            sym          = 8'h00;
            have_sym     = 1'b0;

            // Hunting, then escape removal.
            if (phase == srx_pkg::PH_HUNT) begin
                if (b == srx_pkg::FRAME_END) begin
                    phase    = srx_pkg::PH_LEN_LO;
                    crc_acc  = srx_pkg::CRC_INIT;
                    esc_seen = 1'b0;
                end
            end else if (!esc_seen) begin
                if (b == srx_pkg::FRAME_ESC) begin
                    esc_seen = 1'b1;
                end else begin
                    sym      = b;
                    have_sym = 1'b1;
                end
            end else begin
                esc_seen = 1'b0;
                if (b == srx_pkg::TRANS_END) begin
                    sym      = srx_pkg::FRAME_END;
                    have_sym = 1'b1;
                end else if (b == srx_pkg::TRANS_ESC) begin
                    sym      = srx_pkg::FRAME_ESC;
                    have_sym = 1'b1;
                end else begin
                    phase    = srx_pkg::PH_HUNT;
                    w.status = srx_pkg::ST_BADESC;
                end
            end

            // Frame fields of the decoded symbol.
            if (have_sym) begin
                case (phase)
                    srx_pkg::PH_LEN_LO: begin
                        frame_len = {8'h00, sym};
                        crc_acc   = crc32_step(crc_acc, sym);
                        phase     = srx_pkg::PH_LEN_HI;
                    end
                    srx_pkg::PH_LEN_HI: begin
                        frame_len[15:8] = sym;
                        crc_acc         = crc32_step(crc_acc, sym);
                        pay_count       = '0;
                        if (frame_len == 16'd0) begin
                            phase   = srx_pkg::PH_CRC;
                            crc_idx = '0;
                        end else begin
                            phase = srx_pkg::PH_DATA;
                        end
                    end
                    srx_pkg::PH_DATA: begin
                        w.data_valid = 1'b1;
                        w.data_byte  = sym;
                        crc_acc      = crc32_step(crc_acc, sym);
                        pay_count    = pay_count + 16'd1;
                        if (pay_count >= frame_len) begin
                            phase   = srx_pkg::PH_CRC;
                            crc_idx = '0;
                        end
                    end
                    default: begin
                        crc_rx[crc_idx*8 +: 8] = sym;
                        if (crc_idx == 2'd3) begin
                            crc_idx  = '0;
                            phase    = srx_pkg::PH_HUNT;
                            w.status = (crc_rx == (crc_acc ^ srx_pkg::CRC_INIT)) ?
                                       srx_pkg::ST_GOOD : srx_pkg::ST_BADCRC;
                        end else begin
                            crc_idx = crc_idx + 2'd1;
                        end
                    end
                endcase
            end
            pending_words.push_back(w);
        endfunction

        // Compares one accepted result word with the oldest word still due.
        function void check_word(input logic dv, input logic [7:0] db, input logic [1:0] st);
            srx_pkg::t_result want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected word valid=%0b byte=%02h status=%0d",
                             $realtime, dv, db, st);
                end
                return;
            end
            want = pending_words.pop_front();
            if (dv !== want.data_valid || db !== want.data_byte || st !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch: want v=%0b b=%02h s=%0d, got v=%0b b=%02h s=%0d",
                             $realtime, want.data_valid, want.data_byte, want.status,
                             dv, db, st);
                end
            end
        endfunction
    endclass

    typedef enum {FR_GOOD, FR_BADCRC, FR_CUT} t_frame_kind;

    localparam int unsigned BYTE_TARGET = 1850;
    localparam int unsigned HOLD_CYCLES = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_link_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_data_valid;
    logic [7:0] o_data_byte;
    logic [1:0] o_status;

    slip_rx_tracker tracker = new();
    int unsigned    accepted_bytes = 0;
    bit             holding = 1'b0;
    bit             steady_sender = 1'b0;

    slip_crc32_frame_receiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_link_byte  (i_link_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_valid (o_data_valid),
        .o_data_byte  (o_data_byte),
        .o_status     (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sender idle time: mostly short, now and then long, none during the hold-off or for a steady sender.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (holding || steady_sender) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one link byte and waits until the block takes it.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        i_valid     <= 1'b1;
        i_link_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_link_byte(b);
        accepted_bytes++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one decoded symbol with SLIP escaping; a frame byte may go bare as data.
    task automatic send_symbol(input logic [7:0] sym, input bit bare_ok);
        if (sym == srx_pkg::FRAME_END && bare_ok) begin
            push_byte(sym);
        end else if (sym == srx_pkg::FRAME_END) begin
            push_byte(srx_pkg::FRAME_ESC);
            push_byte(srx_pkg::TRANS_END);
        end else if (sym == srx_pkg::FRAME_ESC) begin
            push_byte(srx_pkg::FRAME_ESC);
            push_byte(srx_pkg::TRANS_ESC);
        end else begin
            push_byte(sym);
        end
    endtask

    // Sends a whole frame; a cut frame stops early on a bad escape.
    task automatic send_frame(input logic [15:0] len, input t_frame_kind kind);
        logic [7:0]  syms[$];
        logic [31:0] crc;
        logic [7:0]  bad;
        int          n;
        int          r;
        crc = srx_pkg::CRC_INIT;
        syms.push_back(len[7:0]);
        syms.push_back(len[15:8]);
        n = (kind == FR_CUT) ? $urandom_range(0, 12) : int'(len);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 11);
            if (r == 0) syms.push_back(srx_pkg::FRAME_END);
            else if (r == 1) syms.push_back(srx_pkg::FRAME_ESC);
            else syms.push_back(8'($urandom_range(0, 255)));
        end
        if (kind != FR_CUT) begin
            foreach (syms[k]) crc = slip_rx_tracker::crc32_step(crc, syms[k]);
            crc = crc ^ srx_pkg::CRC_INIT;
            if (kind == FR_BADCRC) crc = crc ^ (32'h1 << $urandom_range(0, 31));
            for (int k = 0; k < 4; k++) syms.push_back(crc[8*k +: 8]);
        end
        push_byte(srx_pkg::FRAME_END);
        foreach (syms[k]) send_symbol(syms[k], $urandom_range(0, 3) == 0);
        if (kind == FR_CUT) begin
            do begin
                bad = 8'($urandom_range(0, 255));
            end while (bad == srx_pkg::TRANS_END || bad == srx_pkg::TRANS_ESC);
            push_byte(srx_pkg::FRAME_ESC);
            push_byte(bad);
        end
    endtask

    // Stimulus: reset, a few directed frames, then random traffic.
    initial begin
        logic [31:0] crc;
        int          frame_no;
        int          r;
        int          waited;
        logic [15:0] len;
        logic [7:0]  noise;
        t_frame_kind kind;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ignored bytes while hunting.
        push_byte(8'h00);
        push_byte(8'hFF);
        // Empty frame with a good CRC.
        send_frame(16'd0, FR_GOOD);
        // Bad escape straight after the frame start.
        push_byte(srx_pkg::FRAME_END);
        push_byte(srx_pkg::FRAME_ESC);
        push_byte(8'h12);
        // Two payload bytes: a bare frame byte and an escaped escape byte, with a wrong CRC.
        crc = srx_pkg::CRC_INIT;
        crc = slip_rx_tracker::crc32_step(crc, 8'h02);
        crc = slip_rx_tracker::crc32_step(crc, 8'h00);
        crc = slip_rx_tracker::crc32_step(crc, srx_pkg::FRAME_END);
        crc = slip_rx_tracker::crc32_step(crc, srx_pkg::FRAME_ESC);
        crc = crc ^ srx_pkg::CRC_INIT ^ 32'h8000_0000;
        push_byte(srx_pkg::FRAME_END);
        send_symbol(8'h02, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(srx_pkg::FRAME_END, 1'b1);
        send_symbol(srx_pkg::FRAME_ESC, 1'b0);
        for (int k = 0; k < 4; k++) send_symbol(crc[8*k +: 8], 1'b0);

        // Random frames, mostly well formed, with noise and broken frames between.
        frame_no = 0;
        while (accepted_bytes < BYTE_TARGET) begin
            steady_sender = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == srx_pkg::FRAME_END && $urandom_range(0, 7) != 0) noise = 8'h3F;
                    push_byte(noise);
                end
            end
            r = $urandom_range(0, 99);
            kind = (r < 70) ? FR_GOOD : (r < 85) ? FR_BADCRC : FR_CUT;
            r = $urandom_range(0, 99);
            if (kind == FR_CUT) len = 16'($urandom_range(0, 65535));
            else if (frame_no == 20 || frame_no == 55) len = 16'($urandom_range(256, 300));
            else if (r < 10) len = 16'd0;
            else if (r < 60) len = 16'($urandom_range(1, 8));
            else len = 16'($urandom_range(9, 40));
            send_frame(len, kind);
            frame_no++;
        end
        i_valid <= 1'b0;
        steady_sender = 1'b0;

        // Drain the outstanding words, then let the pipeline settle.
        waited = 0;
        while (tracker.pending_words.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
            $display("slip_crc32_frame_receiver_tb OK");
        end else begin
            $display("slip_crc32_frame_receiver_tb NOT OK");
        end
        $finish;
    end

    // Receiver: checks accepted words and stalls at random, with one long hold-off.
    initial begin
        int  run_left;
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                tracker.check_word(o_data_valid, o_data_byte, o_status);
            end
            if (!hold_done && accepted_bytes >= 500) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                holding = 1'b1;
                i_stall <= 1'b1;
            end else begin
                holding = 1'b0;
                if (run_left > 0) begin
                    run_left--;
                    i_stall <= 1'b0;
                end else if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(0, 8);
                    stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                              : $urandom_range(0, 3);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        #5000000;
        $display("slip_crc32_frame_receiver_tb NOT OK");
        $finish;
    end

endmodule
